### rtl/sha256_pkg.sv
// Shared types, constants and round functions of the SHA-256 stream hasher.
package sha256_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenOffset  = 56;
  localparam logic [7:0]  PadMark    = 8'h80;

  // Operations of the compression core.
  localparam logic [2:0] CORE_HOLD  = 3'd0;
  localparam logic [2:0] CORE_LOAD  = 3'd1;
  localparam logic [2:0] CORE_ROUND = 3'd2;
  localparam logic [2:0] CORE_FOLD  = 3'd3;
  localparam logic [2:0] CORE_EMIT  = 3'd4;

  typedef struct packed {
    logic [2:0] op;
    logic [5:0] rnd;
    logic [2:0] idx;
  } core_ctrl_t;

  typedef struct packed {
    logic       shift_byte;
    logic       expand;
    logic [7:0] data;
  } sched_ctrl_t;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

### rtl/sha256_in_if.sv
// Input channel: one message byte word with its flags.
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       end_of_message;

  modport source(output valid, output data_byte, output byte_valid,
                 output end_of_message, input ready);
  modport sink(input valid, input data_byte, input byte_valid,
               input end_of_message, output ready);
endinterface

### rtl/sha256_out_if.sv
// Output channel: one digest word with its position.
interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source(output valid, output digest_word, output word_index,
                 output last_word, input ready);
  modport sink(input valid, input digest_word, input word_index,
               input last_word, output ready);
endinterface

### rtl/sha256_sched.sv
// Block buffer and message schedule window: 16 words, shifted a byte or a word at a time.
module sha256_sched (
  input  logic                    clk_i,
  input  sha256_pkg::sched_ctrl_t ctrl_i,
  output logic [31:0]             w_o
);
  import sha256_pkg::*;

  logic [31:0] win_q [16];
  logic [31:0] win_d [16];
  logic [31:0] next_w;

  // While a block is compressed, word 0 is the current schedule word and
  // word k is the one k rounds ahead.
  assign next_w = small_sigma1(win_q[14]) + win_q[9] + small_sigma0(win_q[1]) + win_q[0];

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      win_d[i] = win_q[i];
    end
    if (ctrl_i.shift_byte) begin
      for (int i = 0; i < 15; i++) begin
        win_d[i] = {win_q[i][23:0], win_q[i+1][31:24]};
      end
      win_d[15] = {win_q[15][23:0], ctrl_i.data};
    end else if (ctrl_i.expand) begin
      for (int i = 0; i < 15; i++) begin
        win_d[i] = win_q[i+1];
      end
      win_d[15] = next_w;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 16; i++) begin
      win_q[i] <= win_d[i];
    end
  end

  assign w_o = win_q[0];

endmodule

### rtl/sha256_core.sv
// Compression core: working variables, round unit and the chaining hash words.
module sha256_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sha256_pkg::core_ctrl_t ctrl_i,
  input  logic [31:0]            w_i,
  output logic [31:0]            h0_o
);
  import sha256_pkg::*;

  logic [31:0] h_q [8];
  logic [31:0] h_d [8];
  logic [31:0] v_q [8];
  logic [31:0] v_d [8];
  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] ch;
  logic [31:0] maj;

  assign ch  = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
  assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t1  = v_q[7] + big_sigma1(v_q[4]) + ch + RoundK[ctrl_i.rnd] + w_i;
  assign t2  = big_sigma0(v_q[0]) + maj;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      h_d[i] = h_q[i];
      v_d[i] = v_q[i];
    end
    case (ctrl_i.op)
      CORE_LOAD: begin
        for (int i = 0; i < 8; i++) begin
          v_d[i] = h_q[i];
        end
      end
      CORE_ROUND: begin
        v_d[0] = t1 + t2;
        v_d[1] = v_q[0];
        v_d[2] = v_q[1];
        v_d[3] = v_q[2];
        v_d[4] = v_q[3] + t1;
        v_d[5] = v_q[4];
        v_d[6] = v_q[5];
        v_d[7] = v_q[6];
      end
      CORE_FOLD: begin
        // One word per cycle: both rings rotate, so after a full turn every
        // hash word has taken its working variable and is back in place.
        for (int i = 0; i < 7; i++) begin
          h_d[i] = h_q[i+1];
          v_d[i] = v_q[i+1];
        end
        h_d[7] = h_q[0] + v_q[0];
        v_d[7] = v_q[0];
      end
      CORE_EMIT: begin
        // The ring refills with the initial values as the digest leaves.
        for (int i = 0; i < 7; i++) begin
          h_d[i] = h_q[i+1];
        end
        h_d[7] = InitHash[ctrl_i.idx];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= InitHash[i];
      end
    end else begin
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= h_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 8; i++) begin
      v_q[i] <= v_d[i];
    end
  end

  assign h0_o = h_q[0];

endmodule

### rtl/sha256_stream_hasher.sv
// Top level of the SHA-256 stream hasher: sequencer, padding and digest output.
//
// A message arrives one byte word at a time and the digest leaves as eight
// 32-bit words, first word first. In the idle state a byte word is taken as
// soon as it is valid. The word that completes a 64-byte block keeps the
// input stalled while the single round unit runs all the rounds, one round per
// cycle, and then one adder folds the working variables into the hash words.
// An end-of-message word starts the padding, which feeds the bytes 0x80,
// zeros and the 64-bit bit length through the same byte path, one per
// cycle, and compresses one or two more blocks; then the eight digest words
// leave through an output register, one per cycle while the sink is ready.
// The input is taken again once the last digest word sits in that register.
module sha256_stream_hasher (
  input  logic         clk_i,
  input  logic         rst_ni,
  sha256_in_if.sink    in_i,
  sha256_out_if.source dig_o
);
  import sha256_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ROUND = 3'd1;
  localparam logic [2:0] ST_FOLD  = 3'd2;
  localparam logic [2:0] ST_PAD   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [5:0]  fill_q, fill_d;
  logic [60:0] len_q, len_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        pad_act_q, pad_act_d;
  logic        mark_q, mark_d;
  logic        lenph_q, lenph_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_word_q, out_word_d;
  logic [2:0]  out_idx_q, out_idx_d;
  logic        out_last_q, out_last_d;

  logic        accept;
  logic        is_len;
  logic [63:0] bit_len;
  logic [7:0]  len_byte;
  logic [31:0] w;
  logic [31:0] h0;
  core_ctrl_t  core_ctrl;
  sched_ctrl_t sched_ctrl;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  // The length bytes go in while the fill count runs from 56 to 63, so its
  // low three bits pick the byte, most significant first.
  assign bit_len  = {len_q, 3'b000};
  assign len_byte = 8'(bit_len >> {~fill_q[2:0], 3'b000});
  assign is_len   = lenph_q || (mark_q && (fill_q == 6'(LenOffset)));

  always_comb begin
    state_d     = state_q;
    fill_d      = fill_q;
    len_d       = len_q;
    rnd_d       = rnd_q;
    cnt_d       = cnt_q;
    pad_act_d   = pad_act_q;
    mark_d      = mark_q;
    lenph_d     = lenph_q;
    out_word_d  = out_word_q;
    out_idx_d   = out_idx_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q && !dig_o.ready;
    core_ctrl   = '{op: CORE_HOLD, rnd: rnd_q, idx: cnt_q};
    sched_ctrl  = '{shift_byte: 1'b0, expand: 1'b0, data: in_i.data_byte};

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          pad_act_d = in_i.end_of_message;
          if (in_i.end_of_message) begin
            state_d = ST_PAD;
          end
          if (in_i.byte_valid) begin
            sched_ctrl.shift_byte = 1'b1;
            fill_d = fill_q + 6'd1;
            len_d  = len_q + 61'd1;
            if (fill_q == 6'(BlockBytes - 1)) begin
              state_d        = ST_ROUND;
              core_ctrl.op   = CORE_LOAD;
              rnd_d          = 6'd0;
            end
          end
        end
      end
      ST_PAD: begin
        sched_ctrl.shift_byte = 1'b1;
        if (!mark_q) begin
          sched_ctrl.data = PadMark;
        end else if (is_len) begin
          sched_ctrl.data = len_byte;
        end else begin
          sched_ctrl.data = 8'h00;
        end
        mark_d  = 1'b1;
        lenph_d = is_len;
        fill_d  = fill_q + 6'd1;
        if (fill_q == 6'(BlockBytes - 1)) begin
          state_d      = ST_ROUND;
          core_ctrl.op = CORE_LOAD;
          rnd_d        = 6'd0;
        end
      end
      ST_ROUND: begin
        core_ctrl.op      = CORE_ROUND;
        sched_ctrl.expand = 1'b1;
        rnd_d             = rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          state_d = ST_FOLD;
          cnt_d   = 3'd0;
        end
      end
      ST_FOLD: begin
        core_ctrl.op = CORE_FOLD;
        cnt_d        = cnt_q + 3'd1;
        if (cnt_q == 3'd7) begin
          if (!pad_act_q) begin
            state_d = ST_IDLE;
          end else if (lenph_q) begin
            state_d = ST_OUT;
          end else begin
            state_d = ST_PAD;
          end
        end
      end
      ST_OUT: begin
        if (!out_valid_q || dig_o.ready) begin
          core_ctrl.op = CORE_EMIT;
          out_valid_d  = 1'b1;
          out_word_d   = h0;
          out_idx_d    = cnt_q;
          out_last_d   = (cnt_q == 3'd7);
          cnt_d        = cnt_q + 3'd1;
          if (cnt_q == 3'd7) begin
            state_d   = ST_IDLE;
            pad_act_d = 1'b0;
            mark_d    = 1'b0;
            lenph_d   = 1'b0;
            len_d     = '0;
            fill_d    = '0;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fill_q      <= '0;
      len_q       <= '0;
      rnd_q       <= '0;
      cnt_q       <= '0;
      pad_act_q   <= 1'b0;
      mark_q      <= 1'b0;
      lenph_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      len_q       <= len_d;
      rnd_q       <= rnd_d;
      cnt_q       <= cnt_d;
      pad_act_q   <= pad_act_d;
      mark_q      <= mark_d;
      lenph_q     <= lenph_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q <= out_word_d;
    out_idx_q  <= out_idx_d;
    out_last_q <= out_last_d;
  end

  sha256_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (sched_ctrl),
    .w_o    (w)
  );

  sha256_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (core_ctrl),
    .w_i    (w),
    .h0_o   (h0)
  );

  assign dig_o.valid       = out_valid_q;
  assign dig_o.digest_word = out_word_q;
  assign dig_o.word_index  = out_idx_q;
  assign dig_o.last_word   = out_last_q;

endmodule
